// ===== rtl/rxfifo_pkg.sv =====
package rxfifo_pkg;

  // Ring geometry: one slot always stays empty, so DEPTH-1 bytes fit
  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_DRAIN = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Update strobes into the statistics unit
  typedef struct packed {
    logic push_stored;
    logic push_dropped;
    logic read_ovr;
    logic read_cnt;
  } stats_req_t;

  // Values returned by the statistics unit, before the update
  typedef struct packed {
    logic ovr_seen;
    cnt_t new_count;
  } stats_rsp_t;

  // Ring increment with wrap at DEPTH
  function automatic idx_t idx_next(input idx_t i);
    idx_t r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rxfifo_if.sv =====
// Request channel: one item per push, pop or drain
interface rxfifo_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       want_overrun;
  logic       want_count;

  modport source (output valid, func, data_byte, want_overrun, want_count, input ready);
  modport sink   (input valid, func, data_byte, want_overrun, want_count, output ready);
endinterface

// Response channel: one item per request
interface rxfifo_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  popped_byte;
  logic        overrun_seen;
  logic [31:0] new_byte_count;

  modport source (output valid, ok, popped_byte, overrun_seen, new_byte_count, input ready);
  modport sink   (input valid, ok, popped_byte, overrun_seen, new_byte_count, output ready);
endinterface

// ===== rtl/rx_byte_ring_fifo_with_stats.sv =====
// Receive byte ring FIFO with overrun and byte-count statistics.
//
// Channels: req (sink) carries func, data_byte, want_overrun, want_count;
// rsp (source) returns ok, popped_byte, overrun_seen, new_byte_count.
// Every request item yields exactly one response item, in order.
// func: push stores a byte unless the ring is full (then the byte is dropped
// and the sticky overrun flag sets); pop returns the oldest byte or ok=0 when
// empty; drain optionally reads and clears the overrun flag and the count of
// bytes stored since the last count drain; code three returns all zeros.
//
// Path: an accepted request passes through the read stage (byte RAM read)
// and then the output register before its response is valid.
// Throughput: one item per cycle while rsp is taken; the RAM has one write and
// one registered read port and each item uses at most one of them.
// Reset (rst, synchronous): ring empty, flag and totals zero, no response
// pending. RAM contents are not cleared; only written slots are ever read.
// Stall: when rsp.ready is low the output holds, the read stage fills and
// req.ready drops until the output drains.
module rx_byte_ring_fifo_with_stats (
  input logic       clk,
  input logic       rst,
  rxfifo_req_if.sink   req,
  rxfifo_rsp_if.source rsp
);

  rxfifo_pkg::idx_t       write_index;
  rxfifo_pkg::idx_t       read_index;
  rxfifo_pkg::idx_t       write_index_next;
  rxfifo_pkg::idx_t       read_index_next;
  rxfifo_pkg::func_t      func;
  rxfifo_pkg::stats_req_t st_req;
  rxfifo_pkg::stats_rsp_t st_rsp;

  logic             accept;
  logic             full;
  logic             empty;
  logic             push_ok;
  logic             pop_ok;
  logic             item_ok;
  logic [7:0]       ram_rdata;

  // Read stage: item waiting on the RAM read
  logic             s1_valid;
  logic             s1_ok;
  logic             s1_pop;
  logic             s1_ovr;
  rxfifo_pkg::cnt_t s1_cnt;
  logic             s1_adv;

  // Output register
  logic             o_valid;
  logic             o_ok;
  logic [7:0]       o_byte;
  logic             o_ovr;
  rxfifo_pkg::cnt_t o_cnt;

  assign func   = rxfifo_pkg::func_t'(req.func);
  assign s1_adv = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept = req.valid && req.ready;

  assign write_index_next = rxfifo_pkg::idx_next(write_index);
  assign read_index_next  = rxfifo_pkg::idx_next(read_index);
  assign full  = (write_index_next == read_index);
  assign empty = (read_index == write_index);

  // Decode the accepted item
  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    item_ok = 1'b0;
    st_req  = '0;
    unique case (func)
      rxfifo_pkg::FUNC_PUSH: begin
        push_ok             = accept && !full;
        item_ok             = !full;
        st_req.push_stored  = accept && !full;
        st_req.push_dropped = accept && full;
      end
      rxfifo_pkg::FUNC_POP: begin
        pop_ok  = accept && !empty;
        item_ok = !empty;
      end
      rxfifo_pkg::FUNC_DRAIN: begin
        item_ok         = 1'b1;
        st_req.read_ovr = accept && req.want_overrun;
        st_req.read_cnt = accept && req.want_count;
      end
      rxfifo_pkg::FUNC_NOP: begin
        item_ok = 1'b0;
      end
      default: begin
        item_ok = 1'b0;
      end
    endcase
  end

  // A pop only reads a slot written by an earlier item, so no forwarding
  rxfifo_ram #(
    .DEPTH_P (rxfifo_pkg::DEPTH),
    .WIDTH_P (8)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (write_index),
    .wdata (req.data_byte),
    .re    (pop_ok),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  rxfifo_stats u_stats (
    .clk (clk),
    .rst (rst),
    .req (st_req),
    .rsp (st_rsp)
  );

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (push_ok) begin
        write_index <= write_index_next;
      end
      if (pop_ok) begin
        read_index <= read_index_next;
      end
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok  <= item_ok;
      s1_pop <= pop_ok;
      s1_ovr <= st_rsp.ovr_seen;
      s1_cnt <= st_rsp.new_count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_ok   <= s1_ok;
      o_byte <= s1_pop ? ram_rdata : 8'd0;
      o_ovr  <= s1_ovr;
      o_cnt  <= s1_cnt;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.ok             = o_ok;
  assign rsp.popped_byte    = o_byte;
  assign rsp.overrun_seen   = o_ovr;
  assign rsp.new_byte_count = o_cnt;

endmodule

// ===== rtl/rxfifo_ram.sv =====
// Simple dual-port RAM, registered read; read data holds when not reading
module rxfifo_ram #(
  parameter int unsigned DEPTH_P = 256,
  parameter int unsigned WIDTH_P = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rxfifo_stats.sv =====
// Sticky overrun flag and stored / reported byte totals
module rxfifo_stats (
  input  logic                   clk,
  input  logic                   rst,
  input  rxfifo_pkg::stats_req_t req,
  output rxfifo_pkg::stats_rsp_t rsp
);

  logic             overrun_flag;
  rxfifo_pkg::cnt_t stored_total;
  rxfifo_pkg::cnt_t reported_total;

  // Values seen by the current item, taken before its update
  assign rsp.ovr_seen  = req.read_ovr & overrun_flag;
  assign rsp.new_count = req.read_cnt ? (stored_total - reported_total) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      overrun_flag   <= 1'b0;
      stored_total   <= '0;
      reported_total <= '0;
    end else begin
      if (req.push_dropped) begin
        overrun_flag <= 1'b1;
      end else if (req.read_ovr) begin
        overrun_flag <= 1'b0;
      end
      if (req.push_stored) begin
        stored_total <= stored_total + rxfifo_pkg::CNT_W'(1);
      end
      if (req.read_cnt) begin
        reported_total <= stored_total;
      end
    end
  end

endmodule

// ===== rtl/rxfifo_chk.sv =====
// Port-level checks on the response channel
module rxfifo_chk (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [7:0]  rsp_popped_byte,
  input logic        rsp_overrun_seen,
  input logic [31:0] rsp_new_byte_count
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_popped_byte)
      && $stable(rsp_overrun_seen) && $stable(rsp_new_byte_count))
    else $error("response changed while stalled");

  // A popped byte comes only from a successful pop, with no statistics
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_popped_byte != 8'd0 |->
      rsp_ok && !rsp_overrun_seen && rsp_new_byte_count == 32'd0)
    else $error("popped byte on a non-pop response");

  // Statistics appear only on a drain, which always reports ok
  a_stats_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_overrun_seen || rsp_new_byte_count != 32'd0) |-> rsp_ok)
    else $error("statistics without ok");

  // Nothing is pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind rx_byte_ring_fifo_with_stats rxfifo_chk u_chk (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ok             (rsp.ok),
  .rsp_popped_byte    (rsp.popped_byte),
  .rsp_overrun_seen   (rsp.overrun_seen),
  .rsp_new_byte_count (rsp.new_byte_count)
);

// ===== sim/tb_top.sv =====
package rx_fifo_check_pkg;
  import rxfifo_pkg::*;

  // One response item as the block should return it
  typedef struct packed {
    logic        ok;
    logic [7:0]  popped_byte;
    logic        overrun_seen;
    logic [31:0] new_byte_count;
  } fifo_rsp_t;

  // Shadow ring plus statistics; holds the responses still owed by the block
  class rx_fifo_scoreboard;
    logic [7:0]  ring_mem [DEPTH];
    int unsigned wr_pos;
    int unsigned rd_pos;
    bit          overrun;
    logic [31:0] stored_total;
    logic [31:0] reported_total;
    fifo_rsp_t   owed_rsp_q[$];
    int unsigned errors;
    int unsigned n_items, n_stored, n_dropped, n_popped, n_pop_empty;
    int unsigned n_drain, n_nop;

    function new();
      wr_pos         = 0;
      rd_pos         = 0;
      overrun        = 1'b0;
      stored_total   = '0;
      reported_total = '0;
      errors         = 0;
      n_items        = 0;
      n_stored       = 0;
      n_dropped      = 0;
      n_popped       = 0;
      n_pop_empty    = 0;
      n_drain        = 0;
      n_nop          = 0;
    endfunction

    function int unsigned pending();
      return owed_rsp_q.size();
    endfunction

    // Update the shadow state for an accepted request and queue its response
    function void note_request(func_t f, logic [7:0] d, logic want_ovr, logic want_cnt);
      fifo_rsp_t   r;
      int unsigned nxt;
      r = '0;
      n_items++;
      case (f)
        FUNC_PUSH: begin
          nxt = (wr_pos + 1) % DEPTH;
          if (nxt != rd_pos) begin
            ring_mem[wr_pos] = d;
            wr_pos           = nxt;
            stored_total     = stored_total + 32'd1;
            r.ok             = 1'b1;
            n_stored++;
          end else begin
            // full ring: byte lost, sticky flag set
            overrun = 1'b1;
            n_dropped++;
          end
        end
        FUNC_POP: begin
          if (rd_pos != wr_pos) begin
            r.ok          = 1'b1;
            r.popped_byte = ring_mem[rd_pos];
            rd_pos        = (rd_pos + 1) % DEPTH;
            n_popped++;
          end else begin
            n_pop_empty++;
          end
        end
        FUNC_DRAIN: begin
          r.ok = 1'b1;
          n_drain++;
          if (want_ovr) begin
            r.overrun_seen = overrun;
            overrun        = 1'b0;
          end
          if (want_cnt) begin
            r.new_byte_count = stored_total - reported_total;
            reported_total   = stored_total;
          end
        end
        default: begin
          n_nop++;
        end
      endcase
      owed_rsp_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    // Compare a returned item with the oldest owed response
    task check_response(logic ok, logic [7:0] popped, logic ovr, logic [31:0] cnt);
      fifo_rsp_t want;
      if (owed_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending", {31'd0, ok}, 32'd0);
      end else begin
        want = owed_rsp_q.pop_front();
        if (ok !== want.ok) begin
          report_mismatch("ok", {31'd0, ok}, {31'd0, want.ok});
        end
        if (popped !== want.popped_byte) begin
          report_mismatch("popped_byte", {24'd0, popped}, {24'd0, want.popped_byte});
        end
        if (ovr !== want.overrun_seen) begin
          report_mismatch("overrun_seen", {31'd0, ovr}, {31'd0, want.overrun_seen});
        end
        if (cnt !== want.new_byte_count) begin
          report_mismatch("new_byte_count", cnt, want.new_byte_count);
        end
      end
    endtask
  endclass

endpackage

module tb_top;
  import rxfifo_pkg::*;
  import rx_fifo_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 367;

  typedef enum int {
    MIX_FILL,
    MIX_EMPTY,
    MIX_BLEND
  } traffic_mix_t;

  logic clk = 1'b0;
  logic rst;

  rxfifo_req_if req ();
  rxfifo_rsp_if rsp ();

  rx_byte_ring_fifo_with_stats u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rx_fifo_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  bit          req_up;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Response side backpressure
  always @(posedge clk) begin
    if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check_response(rsp.ok, rsp.popped_byte, rsp.overrun_seen, rsp.new_byte_count);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  // Drop valid once; further calls in the same step leave it alone
  task automatic lower_valid();
    if (req_up) begin
      req.valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  // Offer one request item and hold it until the block takes it
  task automatic send_item(func_t f, logic [7:0] d, logic want_ovr, logic want_cnt);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      lower_valid();
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.func         <= f;
    req.data_byte    <= d;
    req.want_overrun <= want_ovr;
    req.want_count   <= want_cnt;
    req_up = 1'b1;
    do begin
      @(posedge clk);
    end while (!req.ready);
    sb.note_request(f, d, want_ovr, want_cnt);
  endtask

  // Hold off the sender until the block has answered everything
  task automatic wait_for_responses();
    lower_valid();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random request item, opcode mix chosen by the traffic shape
  task automatic send_random(traffic_mix_t mix);
    int unsigned r;
    func_t       f;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        f = (r < 92) ? FUNC_PUSH : (r < 97) ? FUNC_DRAIN : (r < 99) ? FUNC_POP : FUNC_NOP;
      end
      MIX_EMPTY: begin
        f = (r < 85) ? FUNC_POP : (r < 92) ? FUNC_PUSH : (r < 98) ? FUNC_DRAIN : FUNC_NOP;
      end
      default: begin
        f = (r < 42) ? FUNC_PUSH : (r < 82) ? FUNC_POP : (r < 96) ? FUNC_DRAIN : FUNC_NOP;
      end
    endcase
    send_item(f, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned  phase;
    int unsigned  left;
    int unsigned  seg;
    int unsigned  i;
    traffic_mix_t mix;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.func         <= FUNC_NOP;
    req.data_byte    <= 8'h00;
    req.want_overrun <= 1'b0;
    req.want_count   <= 1'b0;
    req_up         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-ring cases, byte extremes, every drain request combination
    send_item(FUNC_DRAIN, 8'h00, 1'b1, 1'b1);
    send_item(FUNC_POP,   8'hFF, 1'b0, 1'b0);
    send_item(FUNC_PUSH,  8'h00, 1'b0, 1'b0);
    send_item(FUNC_PUSH,  8'hFF, 1'b1, 1'b1);
    send_item(FUNC_PUSH,  8'hA5, 1'b0, 1'b0);
    send_item(FUNC_PUSH,  8'h5A, 1'b0, 1'b0);
    send_item(FUNC_DRAIN, 8'h00, 1'b0, 1'b0);
    send_item(FUNC_DRAIN, 8'h00, 1'b0, 1'b1);
    send_item(FUNC_DRAIN, 8'h00, 1'b1, 1'b0);
    send_item(FUNC_POP,   8'h00, 1'b1, 1'b1);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_NOP,   8'hFF, 1'b1, 1'b1);
    send_item(FUNC_NOP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_PUSH,  8'h80, 1'b1, 1'b1);
    send_item(FUNC_PUSH,  8'h01, 1'b0, 1'b0);
    send_item(FUNC_DRAIN, 8'hFF, 1'b1, 1'b1);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    send_item(FUNC_POP,   8'h00, 1'b0, 1'b0);
    wait_for_responses();

    // Random: each phase opens with a long fill burst to reach overrun,
    // then runs fill, empty and blended segments in random order
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 32;
          recv_stall_pct = 80;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      left = PHASE_ITEMS;
      mix  = MIX_FILL;
      seg  = 280;
      while (left > 0) begin
        for (i = 0; i < seg && left > 0; i++) begin
          send_random(mix);
          left--;
        end
        if ($urandom_range(2) == 0) begin
          wait_for_responses();
        end
        mix = traffic_mix_t'($urandom_range(2));
        seg = $urandom_range(40, 200);
      end
      wait_for_responses();
    end

    // Wait a little longer for any stray response
    repeat (8) @(posedge clk);

    $display("Covered %0d items: %0d stored, %0d dropped when full, %0d pops, %0d on empty",
             sb.n_items, sb.n_stored, sb.n_dropped, sb.n_popped, sb.n_pop_empty);
    $display("Also %0d drains and %0d unused codes, under three backpressure mixes; %0d mismatches",
             sb.n_drain, sb.n_nop, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
